[rtl/core/srcw_pkg.sv]
// Shared types and constants for the clockwise sprite rotation scatter block.
package srcw_pkg;

  // Sequencer phase codes
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_WIDTH  = 3'd1;
  localparam logic [2:0] PH_HEIGHT = 3'd2;
  localparam logic [2:0] PH_ACOUNT = 3'd3;
  localparam logic [2:0] PH_ALPHA  = 3'd4;
  localparam logic [2:0] PH_PIXEL  = 3'd5;

  // Write kinds
  localparam logic [1:0] WK_WORD   = 2'd0;
  localparam logic [1:0] WK_NIBBLE = 2'd1;
  localparam logic [1:0] WK_NONE   = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FORMAT = 2'd1;
  localparam logic [1:0] ST_SIDE   = 2'd2;
  localparam logic [1:0] ST_ACOUNT = 2'd3;

  // Header layout of the destination image
  localparam logic [16:0] DST_FORMAT = 17'd0;
  localparam logic [16:0] DST_HEIGHT = 17'd1;
  localparam logic [16:0] DST_WIDTH  = 17'd2;
  localparam logic [16:0] DST_ACOUNT = 17'd3;
  localparam logic [16:0] HDR_WORDS  = 17'd4;

  // Format nibble expected in the first header word
  localparam logic [3:0] FMT_MASK = 4'hf;
  localparam logic [3:0] FMT_CODE = 4'h5;

  // One destination write
  typedef struct packed {
    logic [16:0] dest_index;
    logic [15:0] data;
    logic [1:0]  write_kind;
    logic [1:0]  nibble_pos;
    logic [1:0]  status;
    logic        run_last;
    logic        image_last;
  } result_t;

endpackage

[rtl/core/srcw_seq.sv]
// Input register and image sequencer: turns each source word into destination writes.
module srcw_seq import srcw_pkg::*; #(
  parameter int unsigned MAX_SIDE = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        src_valid,
  output logic        src_stall,
  input  logic [15:0] word,
  input  logic        start_req,
  input  logic        out_ready,
  output logic        res_load,
  output result_t     res
);

  localparam logic [15:0] MaxSide = 16'(MAX_SIDE);

  // Held input transaction
  logic        held_valid;
  logic [15:0] held_word;
  logic        held_start;

  // Image state
  logic [2:0]  phase,         phase_next;
  logic [13:0] word_position, word_position_next;
  logic [7:0]  source_width,  source_width_next;
  logic [7:0]  source_height, source_height_next;
  logic [13:0] alpha_words,   alpha_words_next;
  logic [7:0]  source_column, source_column_next;
  logic [7:0]  source_row,    source_row_next;
  logic [1:0]  slot,          slot_next;

  logic        emit;
  logic        item_done;
  logic        step_go;
  logic        src_load;

  logic [15:0] area;
  logic [14:0] need;
  logic [15:0] rot_idx;
  logic [8:0]  col_inc;
  logic [7:0]  col_adv;
  logic [7:0]  row_adv;
  logic        row_ok;
  logic [3:0]  nib;
  logic [13:0] wpos_inc;
  logic        alpha_last;

  // Shared arithmetic on the current state
  always_comb begin
    area     = 16'(source_width * source_height);
    need     = 15'((17'(area) + 17'd3) >> 2);
    rot_idx  = 16'(source_column * source_height)
             + 16'(source_height - 8'd1 - source_row);
    col_inc  = 9'(source_column) + 9'd1;
    if (col_inc >= {1'b0, source_width}) begin
      col_adv = 8'd0;
      row_adv = source_row + 8'd1;
    end else begin
      col_adv = col_inc[7:0];
      row_adv = source_row;
    end
    row_ok   = source_row < source_height;
    nib      = held_word[{~slot, 2'b00} +: 4];
    wpos_inc = word_position + 14'd1;
  end

  // Work out one step for the held word
  always_comb begin
    phase_next         = phase;
    word_position_next = word_position;
    source_width_next  = source_width;
    source_height_next = source_height;
    alpha_words_next   = alpha_words;
    source_column_next = source_column;
    source_row_next    = source_row;
    slot_next          = 2'd0;
    emit               = 1'b0;
    item_done          = 1'b1;
    alpha_last         = 1'b1;
    res                = '0;

    if (held_start) begin
      if ((held_word[3:0] & FMT_MASK) != FMT_CODE) begin
        emit           = 1'b1;
        res.write_kind = WK_NONE;
        res.status     = ST_FORMAT;
        res.image_last = 1'b1;
        phase_next     = PH_IDLE;
      end else begin
        source_width_next  = 8'd0;
        source_height_next = 8'd0;
        alpha_words_next   = 14'd0;
        word_position_next = 14'd0;
        source_column_next = 8'd0;
        source_row_next    = 8'd0;
        emit               = 1'b1;
        res.dest_index     = DST_FORMAT;
        res.data           = held_word;
        res.write_kind     = WK_WORD;
        res.run_last       = 1'b1;
        phase_next         = PH_WIDTH;
      end
    end else begin
      case (phase)
        PH_WIDTH, PH_HEIGHT: begin
          emit = 1'b1;
          if (held_word > MaxSide) begin
            res.write_kind = WK_NONE;
            res.status     = ST_SIDE;
            res.image_last = 1'b1;
            phase_next     = PH_IDLE;
          end else begin
            res.data       = held_word;
            res.write_kind = WK_WORD;
            res.run_last   = 1'b1;
            if (phase == PH_WIDTH) begin
              source_width_next = held_word[7:0];
              res.dest_index    = DST_WIDTH;
              phase_next        = PH_HEIGHT;
            end else begin
              source_height_next = held_word[7:0];
              res.dest_index     = DST_HEIGHT;
              phase_next         = PH_ACOUNT;
            end
          end
        end
        PH_ACOUNT: begin
          emit = 1'b1;
          if (held_word != 16'(need)) begin
            res.write_kind = WK_NONE;
            res.status     = ST_ACOUNT;
            res.image_last = 1'b1;
            phase_next     = PH_IDLE;
          end else begin
            alpha_words_next   = held_word[13:0];
            word_position_next = 14'd0;
            source_column_next = 8'd0;
            source_row_next    = 8'd0;
            res.dest_index     = DST_ACOUNT;
            res.data           = held_word;
            res.write_kind     = WK_WORD;
            res.run_last       = 1'b1;
            if (need == 15'd0) begin
              res.image_last = 1'b1;
              phase_next     = PH_IDLE;
            end else begin
              phase_next = PH_ALPHA;
            end
          end
        end
        PH_ALPHA: begin
          // One nibble slot per step; stop early once the pixels run out
          if (row_ok) begin
            emit               = 1'b1;
            res.dest_index     = HDR_WORDS + 17'(rot_idx[15:2]);
            res.data           = {12'd0, nib};
            res.write_kind     = WK_NIBBLE;
            res.nibble_pos     = rot_idx[1:0];
            source_column_next = col_adv;
            source_row_next    = row_adv;
            alpha_last         = (slot == 2'd3) || (row_adv >= source_height);
          end
          res.run_last = alpha_last;
          item_done    = alpha_last;
          if (!alpha_last) begin
            slot_next = slot + 2'd1;
          end else begin
            word_position_next = wpos_inc;
            if (wpos_inc >= alpha_words) begin
              source_column_next = 8'd0;
              source_row_next    = 8'd0;
              phase_next         = PH_PIXEL;
            end
          end
        end
        PH_PIXEL: begin
          emit               = 1'b1;
          res.dest_index     = HDR_WORDS + 17'(alpha_words) + 17'(rot_idx);
          res.data           = held_word;
          res.write_kind     = WK_WORD;
          res.run_last       = 1'b1;
          source_column_next = col_adv;
          source_row_next    = row_adv;
          if (row_adv >= source_height) begin
            res.image_last = 1'b1;
            phase_next     = PH_IDLE;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // Handshake: a step runs when the result register can take it
  assign step_go   = held_valid && (out_ready || !emit);
  assign res_load  = step_go && emit;
  assign src_stall = held_valid && !(step_go && item_done);
  assign src_load  = src_valid && !src_stall;

  // Hold the input transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (src_load) begin
      held_valid <= 1'b1;
    end else if (step_go && item_done) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (src_load) begin
      held_word  <= word;
      held_start <= start_req;
    end
  end

  // Advance the image state on each step
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      word_position <= 14'd0;
      source_width  <= 8'd0;
      source_height <= 8'd0;
      alpha_words   <= 14'd0;
      source_column <= 8'd0;
      source_row    <= 8'd0;
      slot          <= 2'd0;
    end else if (step_go) begin
      phase         <= phase_next;
      word_position <= word_position_next;
      source_width  <= source_width_next;
      source_height <= source_height_next;
      alpha_words   <= alpha_words_next;
      source_column <= source_column_next;
      source_row    <= source_row_next;
      slot          <= slot_next;
    end
  end

endmodule

[rtl/core/srcw_out.sv]
// Result register that drives the destination write channel.
module srcw_out import srcw_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res_in,
  input  logic    stall,
  output logic    valid,
  output logic    ready,
  output result_t res_q
);

  assign ready = !valid || !stall;

  // Track a pending transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  // Capture the payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res_in;
    end
  end

endmodule

[rtl/core/sprite_rotate_cw90_scatter.sv]
// Top level of the clockwise 90-degree sprite rotation scatter block.
// Takes source sprite words (format, width, height, alpha count, alpha words,
// then pixels in row-major order) and emits one destination write per output
// transaction; the destination buffer must be cleared beforehand because
// nibble writes are OR-merged. A new header, pixel or error word is accepted
// every cycle while wr_stall is low; an alpha word holds the input until its
// nibble writes (up to four) are made, as every nibble passes through the
// single result register. A word is held in the input register, then its
// writes in the result register. A word with start_req high always opens a
// new image; a bad format, a side above MAX_SIDE or a wrong alpha count gives
// one no-write result with an error status and image_last set.
module sprite_rotate_cw90_scatter import srcw_pkg::*; #(
  parameter int unsigned MAX_SIDE = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        src_valid,
  output logic        src_stall,
  input  logic [15:0] word,
  input  logic        start_req,
  output logic        wr_valid,
  input  logic        wr_stall,
  output logic [16:0] dest_index,
  output logic [15:0] data,
  output logic [1:0]  write_kind,
  output logic [1:0]  nibble_pos,
  output logic [1:0]  status,
  output logic        run_last,
  output logic        image_last
);

  logic    out_ready;
  logic    res_load;
  result_t res;
  result_t res_q;

  // Sequence the source words
  srcw_seq #(
    .MAX_SIDE(MAX_SIDE)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .word      (word),
    .start_req (start_req),
    .out_ready (out_ready),
    .res_load  (res_load),
    .res       (res)
  );

  // Register the writes
  srcw_out u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (res_load),
    .res_in (res),
    .stall  (wr_stall),
    .valid  (wr_valid),
    .ready  (out_ready),
    .res_q  (res_q)
  );

  assign dest_index = res_q.dest_index;
  assign data       = res_q.data;
  assign write_kind = res_q.write_kind;
  assign nibble_pos = res_q.nibble_pos;
  assign status     = res_q.status;
  assign run_last   = res_q.run_last;
  assign image_last = res_q.image_last;

endmodule

[rtl/core/srcw_chk.sv]
// Port checker for the rotation scatter block, bound to the top level.
module srcw_chk import srcw_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        wr_valid,
  input logic        wr_stall,
  input logic [16:0] dest_index,
  input logic [15:0] data,
  input logic [1:0]  write_kind,
  input logic [1:0]  nibble_pos,
  input logic [1:0]  status,
  input logic        run_last,
  input logic        image_last
);

  // Hold a stalled write transaction
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    wr_valid && wr_stall |=> wr_valid && $stable(dest_index) && $stable(data)
      && $stable(write_kind) && $stable(nibble_pos))
    else $error("stalled write changed");

  // An error result ends the image and carries a nonzero status
  a_abort: assert property (@(posedge clk) disable iff (rst)
    wr_valid && write_kind == WK_NONE |-> image_last && status != ST_OK
      && dest_index == 17'd0 && data == 16'd0)
    else $error("bad abort result");

  // A normal image end is also the last write of its word
  a_image_end: assert property (@(posedge clk) disable iff (rst)
    wr_valid && image_last && write_kind != WK_NONE |-> run_last)
    else $error("image end without run end");

  // Nibble writes carry only a low nibble and report ok
  a_nibble: assert property (@(posedge clk) disable iff (rst)
    wr_valid && write_kind == WK_NIBBLE |-> data[15:4] == 12'd0
      && status == ST_OK && dest_index >= HDR_WORDS && !image_last)
    else $error("malformed nibble write");

  // Whole-word writes use slot zero and report ok
  a_word: assert property (@(posedge clk) disable iff (rst)
    wr_valid && write_kind == WK_WORD |-> nibble_pos == 2'd0 && status == ST_OK)
    else $error("malformed word write");

endmodule

bind sprite_rotate_cw90_scatter srcw_chk u_chk (.*);
